// File: src/xrc_pkg.sv
package xrc_pkg;

	localparam int unsigned BlockBytesDefault = 132;

	localparam logic [7:0] ChSoh = 8'h01;
	localparam logic [7:0] ChEot = 8'h04;
	localparam logic [7:0] ChAck = 8'h06;
	localparam logic [7:0] ChNak = 8'h15;
	localparam logic [7:0] ChCan = 8'h18;

	localparam logic [1:0] StRunning   = 2'd0;
	localparam logic [1:0] StFinished  = 2'd1;
	localparam logic [1:0] StCancelled = 2'd2;
	localparam logic [1:0] StAborted   = 2'd3;

	localparam logic [1:0] CfgIdleTimeout = 2'd0;
	localparam logic [1:0] CfgByteTimeout = 2'd1;
	localparam logic [1:0] CfgNakLimit    = 2'd2;

	localparam logic [15:0] IdleTimeoutReset = 16'd3000;
	localparam logic [15:0] ByteTimeoutReset = 16'd10000;
	localparam logic [3:0]  NakLimitReset    = 4'd3;

	localparam logic ReqByte = 1'b0;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} xrc_item_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] send_byte;
		logic [1:0] link_status;
	} xrc_result_t;

	typedef struct packed {
		logic [15:0] idle_timeout_ms;
		logic [15:0] byte_timeout_ms;
		logic [3:0]  nak_limit;
	} xrc_cfg_t;

endpackage

// File: src/xrc_cfg_regs.sv
module xrc_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_wdata,
	output xrc_pkg::xrc_cfg_t cfg
);
	import xrc_pkg::*;

	xrc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_timeout_ms <= IdleTimeoutReset;
			cfg_q.byte_timeout_ms <= ByteTimeoutReset;
			cfg_q.nak_limit       <= NakLimitReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgIdleTimeout: cfg_q.idle_timeout_ms <= cfg_wdata;
				CfgByteTimeout: cfg_q.byte_timeout_ms <= cfg_wdata;
				CfgNakLimit:    cfg_q.nak_limit       <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/xrc_core.sv
module xrc_core #(
	parameter int unsigned BLOCK_BYTES = xrc_pkg::BlockBytesDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  xrc_pkg::xrc_item_t   item,
	input  xrc_pkg::xrc_cfg_t    cfg,
	output xrc_pkg::xrc_result_t res
);
	import xrc_pkg::*;

	typedef enum logic [2:0] {
		PH_START,
		PH_IDLE,
		PH_BLOCK,
		PH_DONE,
		PH_CANCEL,
		PH_ABORT
	} phase_t;

	localparam logic [7:0] BlockLim = 8'(BLOCK_BYTES);

	phase_t      phase_q, phase_d;
	logic [7:0]  block_cnt_q, block_cnt_d, block_cnt_inc;
	logic [15:0] tick_q, tick_d, tick_inc;
	logic [3:0]  fail_q, fail_d, fail_inc;
	logic [7:0]  send;
	logic        ended;

	assign tick_inc      = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
	assign fail_inc      = (fail_q == 4'hF) ? fail_q : fail_q + 4'd1;
	assign block_cnt_inc = block_cnt_q + 8'd1;
	assign ended = (phase_q == PH_DONE) || (phase_q == PH_CANCEL) || (phase_q == PH_ABORT);

	always_comb begin
		phase_d     = phase_q;
		block_cnt_d = block_cnt_q;
		tick_d      = tick_q;
		fail_d      = fail_q;
		send        = 8'h00;
		case (phase_q)
			PH_START: begin
				send    = ChNak;
				phase_d = PH_IDLE;
				tick_d  = 16'd0;
			end
			PH_IDLE: begin
				if (item.req_type != ReqByte) begin
					if (tick_inc >= cfg.idle_timeout_ms) begin
						send   = ChNak;
						tick_d = 16'd0;
					end else begin
						tick_d = tick_inc;
					end
				end else begin
					tick_d = 16'd0;
					case (item.rx_byte)
						ChSoh: begin
							phase_d     = PH_BLOCK;
							block_cnt_d = 8'd1;
						end
						ChEot: begin
							send    = ChAck;
							phase_d = PH_DONE;
						end
						ChCan: phase_d = PH_CANCEL;
						default: ;
					endcase
				end
			end
			PH_BLOCK: begin
				if (item.req_type != ReqByte) begin
					if (tick_inc >= cfg.byte_timeout_ms) begin
						send        = ChNak;
						tick_d      = 16'd0;
						block_cnt_d = 8'd0;
						fail_d      = fail_inc;
						phase_d     = (fail_inc >= cfg.nak_limit) ? PH_ABORT : PH_IDLE;
					end else begin
						tick_d = tick_inc;
					end
				end else begin
					tick_d = 16'd0;
					if (block_cnt_inc >= BlockLim) begin
						send        = ChAck;
						block_cnt_d = 8'd0;
						phase_d     = PH_IDLE;
					end else begin
						block_cnt_d = block_cnt_inc;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.send_valid = (send != 8'h00);
		res.send_byte  = send;
		case (phase_d)
			PH_DONE:   res.link_status = StFinished;
			PH_CANCEL: res.link_status = StCancelled;
			PH_ABORT:  res.link_status = StAborted;
			default:   res.link_status = StRunning;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			block_cnt_q <= 8'd0;
			tick_q      <= 16'd0;
			fail_q      <= 4'd0;
		end else if (take) begin
			phase_q     <= phase_d;
			block_cnt_q <= block_cnt_d;
			tick_q      <= tick_d;
			fail_q      <= fail_d;
		end
	end

	a_ended_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ended |=> $stable(phase_q))
		else $error("ended link changed phase");

	a_ended_silent: assert property (@(posedge clk) disable iff (!arst_n)
		ended |-> !res.send_valid)
		else $error("ended link sends a control byte");

	a_count_outside_block: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_BLOCK) |-> (block_cnt_q == 8'd0))
		else $error("block byte count nonzero outside a block");

	a_abort_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_d == PH_ABORT && phase_q != PH_ABORT) |-> (send == ChNak))
		else $error("abort without NAK");

endmodule

// File: src/xmodem_receive_control_unit.sv
// Path: a transaction is taken into the input register, then into the result register;
// a result stall can hold it in the input register.
// Throughput: one transaction per cycle while result_stall is low; the state update is a single pass.
// While a result waits on stall, one more transaction is taken into the input register.
// Reset: arst_n clears the link state to start (first transaction gets NAK)
// and loads timeouts 3000 and 10000 and NAK limit 3.
module xmodem_receive_control_unit #(
	parameter int unsigned BLOCK_BYTES = xrc_pkg::BlockBytesDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  xrc_pkg::xrc_item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output xrc_pkg::xrc_result_t result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_wdata
);
	import xrc_pkg::*;

	xrc_cfg_t    cfg;
	xrc_item_t   item_s1;
	logic        valid_s1;
	xrc_result_t res;
	xrc_result_t result_s2;
	logic        valid_s2;
	logic        move_s1;
	logic        take_in;

	assign move_s1    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !move_s1;
	assign take_in    = item_valid && !item_stall;

	xrc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	xrc_core #(
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (move_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item;
		end
		if (move_s1) begin
			result_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	a_send_code: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.send_valid) |->
			(result_s2.send_byte == ChAck || result_s2.send_byte == ChNak))
		else $error("control byte is neither ACK nor NAK");

	a_no_send_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result_s2.send_valid) |-> (result_s2.send_byte == 8'h00))
		else $error("idle result carries a byte");

	a_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("input stage did not advance into empty result register");

endmodule

// File: dv/tb_xmodem_receive_control_unit.sv
module tb_xmodem_receive_control_unit;
	import xrc_pkg::*;

	localparam logic ReqTick = !ReqByte;
	localparam int QuietLimit = 2000;
	localparam int RandomItems = 900;

	typedef enum logic [2:0] {
		LinkStart,
		LinkIdle,
		LinkBlock,
		LinkDone,
		LinkCancel,
		LinkAbort
	} link_phase_e;

	class link_scoreboard;
		xrc_result_t replies_due[$];
		int errors;
		logic [15:0] idle_limit;
		logic [15:0] gap_limit;
		logic [3:0] fail_limit;
		link_phase_e phase;
		logic [7:0] block_count;
		logic [15:0] quiet_ticks;
		logic [3:0] failed_blocks;

		function new();
			errors = 0;
			idle_limit = IdleTimeoutReset;
			gap_limit = ByteTimeoutReset;
			fail_limit = NakLimitReset;
			phase = LinkStart;
			block_count = '0;
			quiet_ticks = '0;
			failed_blocks = '0;
		endfunction

		function void write_reg(logic [1:0] sel, logic [15:0] value);
			case (sel)
				CfgIdleTimeout: idle_limit = value;
				CfgByteTimeout: gap_limit = value;
				CfgNakLimit: fail_limit = value[3:0];
				default: ;
			endcase
		endfunction

		function void note_item(xrc_item_t rx);
			xrc_result_t want;
			logic [7:0] ctrl;
			ctrl = 8'h00;
			case (phase)
				LinkStart: begin
					ctrl = ChNak;
					phase = LinkIdle;
					quiet_ticks = '0;
				end
				LinkIdle: begin
					if (rx.req_type != ReqByte) begin
						if (quiet_ticks != 16'hFFFF) quiet_ticks++;
						if (quiet_ticks >= idle_limit) begin
							ctrl = ChNak;
							quiet_ticks = '0;
						end
					end else begin
						quiet_ticks = '0;
						if (rx.rx_byte == ChSoh) begin
							phase = LinkBlock;
							block_count = 8'd1;
						end else if (rx.rx_byte == ChEot) begin
							ctrl = ChAck;
							phase = LinkDone;
						end else if (rx.rx_byte == ChCan) begin
							phase = LinkCancel;
						end
					end
				end
				LinkBlock: begin
					if (rx.req_type != ReqByte) begin
						if (quiet_ticks != 16'hFFFF) quiet_ticks++;
						if (quiet_ticks >= gap_limit) begin
							ctrl = ChNak;
							quiet_ticks = '0;
							block_count = '0;
							if (failed_blocks != 4'hF) failed_blocks++;
							phase = (failed_blocks >= fail_limit) ? LinkAbort : LinkIdle;
						end
					end else begin
						quiet_ticks = '0;
						block_count = block_count + 8'd1;
						if (block_count >= BlockBytesDefault) begin
							ctrl = ChAck;
							block_count = '0;
							phase = LinkIdle;
						end
					end
				end
				default: ;
			endcase
			want.send_valid = (ctrl != 8'h00);
			want.send_byte = ctrl;
			case (phase)
				LinkDone: want.link_status = StFinished;
				LinkCancel: want.link_status = StCancelled;
				LinkAbort: want.link_status = StAborted;
				default: want.link_status = StRunning;
			endcase
			replies_due.push_back(want);
		endfunction

		function void check_reply(xrc_result_t got);
			xrc_result_t want;
			if (replies_due.size() == 0) begin
				$display("%0t: expected no transaction, actual %h", $time, got);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			if (got.send_valid !== want.send_valid) begin
				$display("%0t: send_valid expected %0d actual %0d", $time,
					want.send_valid, got.send_valid);
				errors++;
			end
			if (got.send_byte !== want.send_byte) begin
				$display("%0t: send_byte expected %h actual %h", $time,
					want.send_byte, got.send_byte);
				errors++;
			end
			if (got.link_status !== want.link_status) begin
				$display("%0t: link_status expected %0d actual %0d", $time,
					want.link_status, got.link_status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	xrc_item_t req = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	xrc_result_t reply;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CfgIdleTimeout;
	logic [15:0] cfg_wdata = '0;

	link_scoreboard replies;
	bit steady = 1'b0;
	int items_sent = 0;
	int stall_run = 0;
	int stall_roll;
	int quiet;

	xmodem_receive_control_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(req),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(reply),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (result_valid === 1'b1 && result_stall === 1'b0) replies.check_reply(reply);
		if (stall_run > 0) begin
			stall_run--;
			result_stall <= 1'b1;
		end else if (steady) begin
			result_stall <= 1'b0;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 70) begin
				result_stall <= 1'b0;
			end else begin
				stall_run = (stall_roll < 94) ? $urandom_range(0, 2) : $urandom_range(5, 30);
				result_stall <= 1'b1;
			end
		end
	end

	initial begin
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((item_valid === 1'b1 && item_stall === 1'b0) ||
				(result_valid === 1'b1 && result_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_item(logic kind, logic [7:0] data);
		int roll;
		int gap;
		req <= {kind, data};
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall !== 1'b0);
		replies.note_item(req);
		items_sent++;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60) gap = 0;
		else if (roll < 92) gap = $urandom_range(1, 3);
		else gap = $urandom_range(5, 40);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_item(ReqTick, 8'($urandom_range(0, 255)));
	endtask

	// Drop the block after a random byte when broken; hold intra-block gaps under the timeout.
	task automatic send_block(bit broken);
		int cut;
		cut = broken ? $urandom_range(1, BlockBytesDefault - 1) : BlockBytesDefault;
		send_item(ReqByte, ChSoh);
		for (int i = 1; i < cut; i++) begin
			if (replies.gap_limit > 1 && $urandom_range(0, 7) == 0)
				send_ticks($urandom_range(1, (replies.gap_limit > 4) ? 3 : replies.gap_limit - 1));
			send_item(ReqByte, 8'($urandom_range(0, 255)));
		end
		if (broken) send_ticks((replies.gap_limit == 0) ? 1 : replies.gap_limit);
	endtask

	task automatic program_regs(logic [15:0] idle_v, logic [15:0] gap_v, logic [3:0] fail_v);
		logic [1:0] sel [3];
		logic [15:0] vals [3];
		sel = '{CfgIdleTimeout, CfgByteTimeout, CfgNakLimit};
		vals = '{idle_v, gap_v, {12'd0, fail_v}};
		item_valid <= 1'b0;
		while (replies.replies_due.size() != 0) @(posedge clk);
		for (int i = 0; i < 3; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= sel[i];
			cfg_wdata <= vals[i];
			replies.write_reg(sel[i], vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_timeout();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return 16'd1;
		if (roll == 1) return 16'hFFFF;
		return 16'($urandom_range(2, 12));
	endfunction

	function automatic logic [3:0] pick_nak_limit();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return 4'd1;
		if (roll == 1) return 4'd15;
		return 4'($urandom_range(2, 14));
	endfunction

	initial begin
		int base;
		int pick;
		int ending;
		logic [7:0] noise;

		replies = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		program_regs(16'd5, 16'd7, 4'd15);
		send_item(ReqTick, 8'hFF);
		send_item(ReqByte, 8'h00);
		send_item(ReqByte, 8'hFF);
		send_item(ReqByte, ChAck);
		send_item(ReqByte, ChNak);
		send_ticks(4);
		send_item(ReqByte, 8'h80);
		send_ticks(5);
		send_item(ReqByte, ChSoh);
		send_item(ReqByte, ChEot);
		send_item(ReqByte, ChCan);
		send_item(ReqByte, ChSoh);
		send_ticks(7);

		program_regs(16'hFFFF, 16'hFFFF, 4'd15);
		steady = 1'b1;
		send_ticks(20);
		send_item(ReqByte, ChSoh);
		send_ticks(20);
		steady = 1'b0;

		program_regs(16'd0, 16'd2, 4'd15);
		send_ticks(3);
		send_item(ReqByte, 8'h7E);
		program_regs(16'd20, 16'd2, 4'd15);
		send_ticks(10);
		program_regs(16'd4, 16'd2, 4'd15);
		send_ticks(1);

		base = items_sent;
		while (items_sent - base < RandomItems) begin
			program_regs(pick_timeout(), pick_timeout(), pick_nak_limit());
			steady = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(3, 8)) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					send_block(replies.gap_limit <= 64 &&
						int'(replies.failed_blocks) + 1 < int'(replies.fail_limit) &&
						$urandom_range(0, 3) == 0);
				end else if (pick < 8) begin
					repeat ($urandom_range(1, 5)) begin
						do noise = 8'($urandom_range(0, 255));
						while (noise == ChSoh || noise == ChEot || noise == ChCan);
						send_item(ReqByte, noise);
					end
				end else begin
					send_ticks($urandom_range(1,
						(replies.idle_limit < 10) ? 2 * replies.idle_limit : 20));
				end
			end
			steady = 1'b0;
		end

		ending = $urandom_range(0, 2);
		if (ending == 0) begin
			send_item(ReqByte, ChEot);
		end else if (ending == 1) begin
			send_item(ReqByte, ChCan);
		end else begin
			program_regs(pick_timeout(), 16'($urandom_range(0, 1)), 4'($urandom_range(0, 1)));
			send_item(ReqByte, ChSoh);
			send_ticks(1);
		end
		repeat (20) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

		item_valid <= 1'b0;
		while (replies.replies_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (replies.errors == 0 && replies.replies_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
src/xrc_pkg.sv
src/xrc_cfg_regs.sv
src/xrc_core.sv
src/xmodem_receive_control_unit.sv
dv/tb_xmodem_receive_control_unit.sv
